[design/lifetime_hour_meter_assert.svh]
// ----------------------------------------------------------------------------
// Lifetime hour meter assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LIFETIME_HOUR_METER_ASSERT_SVH
`define LIFETIME_HOUR_METER_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define LHM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lifetime_hour_meter check failed")
// Property checked at every clock edge, reset included
`define LHM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lifetime_hour_meter check failed")
`else
`define LHM_ASSERT(lbl, prop)
`define LHM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[design/lhm_pkg.sv]
// ----------------------------------------------------------------------------
// lhm_pkg
// Constants and register codes for the lifetime hour meter.
// ----------------------------------------------------------------------------
package lhm_pkg;

  localparam int TOTAL_BITS_DEF = 21;
  localparam int THR_W          = 21;
  localparam int CNT_W          = 8;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CNT_W-1:0] SEC_PER_MIN    = CNT_W'(60);
  localparam logic [CNT_W-1:0] TICKS_PER_SAVE = CNT_W'(60);

  localparam logic [THR_W-1:0] WARN_RST  = THR_W'(1050000);
  localparam logic [THR_W-1:0] LIMIT_RST = THR_W'(1140000);
  localparam logic [CNT_W-1:0] SAVE_RST  = CNT_W'(30);
  localparam logic [CNT_W-1:0] STEP_RST  = CNT_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARN  = 2'd0,
    CFG_LIMIT = 2'd1,
    CFG_SAVE  = 2'd2,
    CFG_STEP  = 2'd3
  } cfg_idx_t;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

endpackage

[design/lifetime_hour_meter.sv]
// ----------------------------------------------------------------------------
// lifetime_hour_meter
// Accumulated run-time meter in minutes with warning and limit flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per one-second tick or per load of a stored total
//   (s_tuser selects which). Every word in gives exactly one word out on m_*,
//   carrying the total, a save request and the two sticky threshold flags.
//   cfg_* writes the thresholds, the save interval and the speed-up step;
//   write only while the meter is idle.
// Flow and throughput:
//   A word taken sits in the input register, is evaluated there against the
//   meter state and is then captured in the result register that drives m_*.
//   One word per cycle is taken continuously while m_tready stays high; the
//   state update uses adders, two threshold compares and counter logic per item.
// Reset:
//   rst clears total, counters and flags and loads the default configuration.
// Stall:
//   While m_tready is low the result word holds; one more word can wait in the
//   input register, after which s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
module lifetime_hour_meter #(
  parameter int TOTAL_BITS = lhm_pkg::TOTAL_BITS_DEF,
  localparam int IN_W  = ((TOTAL_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_W = ((TOTAL_BITS + 3 + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // slave side
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_W-1:0]              s_tdata,  // powered, speed_up, load_minutes
  input  logic                         s_tuser,  // func
  // master side
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // total_minutes, save_request, warning_reached, limit_reached
  output logic [OUT_W-1:0]             m_tdata,
  // configuration
  input  logic                         cfg_we,
  input  logic [lhm_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lhm_pkg::THR_W-1:0]    cfg_data
);

`include "lifetime_hour_meter_assert.svh"

  localparam int CNT_W = lhm_pkg::CNT_W;
  localparam int THR_W = lhm_pkg::THR_W;

  // configuration registers
  logic [THR_W-1:0] warn_threshold;
  logic [THR_W-1:0] limit_threshold;
  logic [CNT_W-1:0] save_interval;
  logic [CNT_W-1:0] speedup_step;

  // meter state
  logic [TOTAL_BITS-1:0] minute_total, minute_total_next;
  logic [CNT_W-1:0]      second_count, second_count_next;
  logic [CNT_W-1:0]      minute_count, minute_count_next;
  logic                  warn_flag, warn_flag_next;
  logic                  limit_flag, limit_flag_next;
  logic                  save_next;

  // input register
  logic                  in_valid;
  logic                  in_func;
  logic                  in_powered;
  logic                  in_speed;
  logic [TOTAL_BITS-1:0] in_load;

  // result register
  logic                  out_valid;
  logic [TOTAL_BITS-1:0] out_total;
  logic                  out_save;
  logic                  out_warn;
  logic                  out_limit;

  logic adv;
  logic [TOTAL_BITS-1:0] lim_val, warn_val;
  logic [TOTAL_BITS:0]   sum_speed, sum_norm;
  logic [CNT_W-1:0]      sec_inc;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      warn_threshold  <= lhm_pkg::WARN_RST;
      limit_threshold <= lhm_pkg::LIMIT_RST;
      save_interval   <= lhm_pkg::SAVE_RST;
      speedup_step    <= lhm_pkg::STEP_RST;
    end else if (cfg_we) begin
      unique case (lhm_pkg::cfg_idx_t'(cfg_addr))
        lhm_pkg::CFG_WARN:  warn_threshold  <= cfg_data;
        lhm_pkg::CFG_LIMIT: limit_threshold <= cfg_data;
        lhm_pkg::CFG_SAVE:  save_interval   <= cfg_data[CNT_W-1:0];
        lhm_pkg::CFG_STEP:  speedup_step    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func    <= s_tuser;
      in_powered <= s_tdata[0];
      in_speed   <= s_tdata[1];
      in_load    <= s_tdata[2 +: TOTAL_BITS];
    end
  end

  // thresholds resized to the total width
  assign lim_val   = TOTAL_BITS'(limit_threshold);
  assign warn_val  = TOTAL_BITS'(warn_threshold);
  assign sum_speed = {1'b0, minute_total} + (TOTAL_BITS+1)'(speedup_step);
  assign sum_norm  = {1'b0, minute_total} + (TOTAL_BITS+1)'(1);
  assign sec_inc   = second_count + CNT_W'(1);

  always_comb begin
    minute_total_next = minute_total;
    second_count_next = second_count;
    minute_count_next = minute_count;
    warn_flag_next    = warn_flag;
    limit_flag_next   = limit_flag;
    save_next         = 1'b0;
    if (in_func == lhm_pkg::FUNC_LOAD) begin
      second_count_next = '0;
      minute_count_next = '0;
      if (in_load >= lim_val) begin
        minute_total_next = lim_val;
        limit_flag_next   = 1'b1;
      end else begin
        minute_total_next = in_load;
        if (in_load >= warn_val) warn_flag_next = 1'b1;
      end
    end else if (in_powered) begin
      if (in_speed) begin
        second_count_next = sec_inc;
        if (sum_speed >= {1'b0, lim_val}) begin
          minute_total_next = lim_val;
          if (!limit_flag) begin
            limit_flag_next = 1'b1;
            save_next       = 1'b1;
          end
        end else begin
          minute_total_next = sum_speed[TOTAL_BITS-1:0];
          if (sum_speed >= {1'b0, warn_val} && !warn_flag) begin
            // first warning: clamp down and restart the tick count
            minute_total_next = warn_val;
            second_count_next = '0;
            warn_flag_next    = 1'b1;
            save_next         = 1'b1;
          end
          if (second_count_next >= lhm_pkg::TICKS_PER_SAVE) begin
            second_count_next = '0;
            save_next         = 1'b1;
          end
        end
      end else if (sec_inc < lhm_pkg::SEC_PER_MIN) begin
        second_count_next = sec_inc;
      end else begin
        second_count_next = '0;
        minute_count_next = minute_count + CNT_W'(1);
        if (sum_norm >= {1'b0, lim_val}) begin
          minute_total_next = lim_val;
          if (!limit_flag) begin
            limit_flag_next = 1'b1;
            save_next       = 1'b1;
          end
        end else begin
          minute_total_next = sum_norm[TOTAL_BITS-1:0];
          if (sum_norm[TOTAL_BITS-1:0] == warn_val) begin
            warn_flag_next    = 1'b1;
            save_next         = 1'b1;
            minute_count_next = '0;
          end
          if (minute_count_next == save_interval) begin
            minute_count_next = '0;
            save_next         = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_total <= '0;
      second_count <= '0;
      minute_count <= '0;
      warn_flag    <= 1'b0;
      limit_flag   <= 1'b0;
    end else if (adv) begin
      minute_total <= minute_total_next;
      second_count <= second_count_next;
      minute_count <= minute_count_next;
      warn_flag    <= warn_flag_next;
      limit_flag   <= limit_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_total <= minute_total_next;
      out_save  <= save_next;
      out_warn  <= warn_flag_next;
      out_limit <= limit_flag_next;
    end
  end

  always_comb begin
    m_tdata                      = '0;
    m_tdata[0 +: TOTAL_BITS]     = out_total;
    m_tdata[TOTAL_BITS]          = out_save;
    m_tdata[TOTAL_BITS + 1]      = out_warn;
    m_tdata[TOTAL_BITS + 2]      = out_limit;
  end

  assign m_tvalid = out_valid;

  // checks
  `LHM_ASSERT(a_limit_sticky, limit_flag |=> limit_flag);
  `LHM_ASSERT(a_warn_sticky, warn_flag |=> warn_flag);
  `LHM_ASSERT(a_load_no_save,
    adv && in_func == lhm_pkg::FUNC_LOAD |=> !out_save);
  `LHM_ASSERT(a_unpowered_hold,
    adv && in_func == lhm_pkg::FUNC_TICK && !in_powered |=>
      $stable(minute_total) && $stable(second_count) && !out_save);
  `LHM_ASSERT(a_stall_keeps_item,
    in_valid && out_valid && !m_tready |=> in_valid && out_valid);
  `LHM_ASSERT_ALWAYS(a_reset_clears, rst |=> !in_valid && !out_valid);

endmodule
